[hdl/ngll_pkg.sv]
// shared types, constants and prefix table for the gll sentence capture block
package ngll_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam int PREFIX_LEN      = 6;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_FETCH,
		RD_HOLD
	} rd_state_t;

	typedef struct packed {
		logic wr_en;
		logic sentence_ready;
	} cap_stat_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h24; // $
			3'd1:    ch = 8'h47; // G
			3'd2:    ch = 8'h4E; // N
			3'd3:    ch = 8'h47; // G
			3'd4:    ch = 8'h4C; // L
			3'd5:    ch = 8'h4C; // L
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

[hdl/ngll_capture.sv]
// prefix hunt, store write addressing and end-of-line detection
module ngll_capture #(
	parameter int STORE_DEPTH = ngll_pkg::STORE_DEPTH_DEF,
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_take,
	input  logic [7:0]          rx_byte,
	input  logic                overrun,
	input  logic                rel_take,
	output ngll_pkg::cap_stat_t stat,
	output logic [AW-1:0]       wr_addr,
	output logic [AW-1:0]       term_pos
);
	import ngll_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

	logic [AW-1:0] wp_q;
	logic [2:0]    mp_q;
	logic          pf_q;
	logic          sr_q;
	// copies of the two entries just below the write position
	logic [7:0]    e1_q;
	logic [7:0]    e2_q;
	logic [AW-1:0] term_q;

	logic          take;
	logic [AW-1:0] wp0;
	logic [2:0]    mp0;
	logic [2:0]    mp_inc;
	logic          sat;
	logic          hit;
	logic [AW-1:0] wp_nx;
	logic [2:0]    mp_nx;
	logic          pf_nx;
	logic [7:0]    e1_nx;
	logic [7:0]    e2_nx;
	logic          term_hit;

	always_comb begin
		take   = byte_take && !sr_q;
		wp0    = overrun ? '0 : wp_q;
		mp0    = overrun ? 3'd0 : mp_q;
		mp_inc = mp0 + 3'd1;
		sat    = (wp0 == LAST);
		hit    = !pf_q && (mp0 < 3'(PREFIX_LEN)) && (rx_byte == prefix_char(mp0));
		wp_nx  = sat ? wp0 : wp0 + 1'b1;
		mp_nx  = 3'd0;
		pf_nx  = pf_q;
		if (hit) begin
			if (mp_inc == 3'(PREFIX_LEN)) begin
				pf_nx = 1'b1;
			end else begin
				mp_nx = mp_inc;
			end
		end else if (!pf_q) begin
			wp_nx = '0;
		end
		// once saturated, writes land on the top entry and the two below stay put
		e1_nx    = sat ? e1_q : rx_byte;
		e2_nx    = sat ? e2_q : e1_q;
		term_hit = pf_nx && (wp_nx >= AW'(2)) && (e1_nx == CH_LF) && (e2_nx == CH_CR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			mp_q <= 3'd0;
			pf_q <= 1'b0;
			sr_q <= 1'b0;
		end else if (take) begin
			wp_q <= term_hit ? '0 : wp_nx;
			mp_q <= term_hit ? 3'd0 : mp_nx;
			pf_q <= pf_nx && !term_hit;
			if (term_hit) begin
				sr_q <= 1'b1;
			end
		end else if (rel_take) begin
			sr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			e1_q <= e1_nx;
			e2_q <= e2_nx;
			if (term_hit) begin
				term_q <= wp_nx - AW'(2);
			end
		end
	end

	assign stat.wr_en          = take;
	assign stat.sentence_ready = sr_q;
	assign wr_addr             = wp0;
	assign term_pos            = term_q;

`ifndef SYNTHESIS
	a_hunt_or_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pf_q |-> !sr_q)
		else $error("prefix found while a sentence is held");

	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		mp_q < 3'(PREFIX_LEN))
		else $error("match position out of range");

	a_held_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(sr_q && byte_take) |=> ($stable(wp_q) && sr_q))
		else $error("capture moved while a sentence is held");
`endif

endmodule

[hdl/nmea_gll_sentence_capture_unit.sv]
// gll sentence capture: line store, read streaming and output register
// received byte: one per cycle if output free, no result, stored same cycle unless held
// read request: the read port registers each entry, fetch loads it into the output register,
//   hold waits for its transfer; final zero item at the end, no new input until then
// a read with no held sentence gives its single item in the cycle after the transfer
// arst_n clears positions, flags, read state and output valid; the store is not cleared
module nmea_gll_sentence_capture_unit #(
	parameter int STORE_DEPTH = ngll_pkg::STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	input  logic        overrun,
	input  logic [15:0] read_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ready_res,
	output logic [7:0]  out_char,
	output logic        last
);
	import ngll_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

	logic [7:0]    store_mem [STORE_DEPTH];
	logic [7:0]    rd_data_s1;

	rd_state_t     state_q, state_d;
	logic [AW-1:0] k_q, k_d;
	logic [AW-1:0] cap_q;
	logic [AW-1:0] cap_nx;
	logic [15:0]   lim_m1;

	logic          out_valid_q;
	logic          ready_res_q;
	logic [7:0]    out_char_q;
	logic          last_q;

	logic          load_out;
	logic          ld_ready;
	logic [7:0]    ld_char;
	logic          ld_last;

	logic          in_take;
	logic          out_take;
	logic          byte_take;
	logic          rd_take;
	logic          rel_take;
	cap_stat_t     stat;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] term_pos;

	assign in_ready  = (state_q == RD_IDLE) && (!out_valid_q || out_ready);
	assign in_take   = in_valid && in_ready;
	assign out_take  = out_valid_q && out_ready;
	assign byte_take = in_take && (kind == KIND_BYTE);
	assign rd_take   = in_take && (kind == KIND_READ);
	assign rel_take  = rd_take && stat.sentence_ready;

	ngll_capture #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_capture (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_take(byte_take),
		.rx_byte  (rx_byte),
		.overrun  (overrun),
		.rel_take (rel_take),
		.stat     (stat),
		.wr_addr  (wr_addr),
		.term_pos (term_pos)
	);

	// character cap: read_limit minus one, floored at zero, capped at the top entry
	always_comb begin
		lim_m1 = read_limit - 16'd1;
		if (read_limit == 16'd0) begin
			cap_nx = '0;
		end else if (lim_m1 > 16'(STORE_DEPTH - 1)) begin
			cap_nx = LAST;
		end else begin
			cap_nx = lim_m1[AW-1:0];
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		load_out = 1'b0;
		ld_ready = 1'b1;
		ld_char  = CH_NUL;
		ld_last  = 1'b1;
		case (state_q)
			RD_IDLE: begin
				k_d = '0;
				if (rel_take) begin
					state_d = RD_FETCH;
				end else if (rd_take) begin
					load_out = 1'b1;
					ld_ready = 1'b0;
				end
			end
			RD_FETCH: begin
				load_out = 1'b1;
				// the held carriage return reads as the terminator
				if ((k_q < cap_q) && (k_q != term_pos) && (rd_data_s1 != CH_NUL)) begin
					ld_char = rd_data_s1;
					ld_last = 1'b0;
					state_d = RD_HOLD;
				end else begin
					state_d = RD_IDLE;
				end
			end
			RD_HOLD: begin
				if (out_take) begin
					k_d     = k_q + 1'b1;
					state_d = RD_FETCH;
				end
			end
			default: begin
				state_d = RD_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= RD_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_take) begin
			cap_q <= cap_nx;
		end
		if (load_out) begin
			ready_res_q <= ld_ready;
			out_char_q  <= ld_char;
			last_q      <= ld_last;
		end
	end

	// line store: one write port for captured bytes, one registered read port
	always_ff @(posedge clk) begin
		if (stat.wr_en) begin
			store_mem[wr_addr] <= rx_byte;
		end
		rd_data_s1 <= store_mem[k_d];
	end

	assign out_valid = out_valid_q;
	assign ready_res = ready_res_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_read_starts: assert property (@(posedge clk) disable iff (!arst_n)
		rel_take |=> ((state_q == RD_FETCH) && (k_q == '0) && !stat.sentence_ready))
		else $error("read of a held sentence did not start at entry zero");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && out_valid_q) |-> out_ready)
		else $error("output register overwritten before transfer");

	a_cap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RD_FETCH) |-> (k_q <= cap_q))
		else $error("read index passed the character cap");
`endif

endmodule

[bench/tb.sv]
// testbench for the gll sentence capture unit: directed table, random sentences, predictor check
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ngll_pkg::*;

	localparam int DEPTH      = STORE_DEPTH_DEF;
	localparam int DIR_ROWS   = 27;
	localparam int RAND_ITEMS = 240;
	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE     = 20;

	localparam logic [7:0] GLL_PREFIX [PREFIX_LEN] = '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h4C, 8'h4C};

	typedef struct packed {
		logic       rdy;
		logic [7:0] ch;
		logic       lst;
	} gll_item_t;

	typedef struct packed {
		logic       k;
		logic [7:0] b;
		logic       ovr;
		logic [15:0] lim;
		logic       typed;
		gll_item_t  res;
	} stim_row_t;

	localparam gll_item_t NONE_HELD    = '{1'b0, CH_NUL, 1'b1};
	localparam gll_item_t END_ONLY     = '{1'b1, CH_NUL, 1'b1};
	localparam gll_item_t FROM_PREDICT = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = KIND_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic        overrun = 1'b0;
	logic [15:0] read_limit = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        ready_res;
	logic [7:0]  out_char;
	logic        last;

	// typed expectation riding along with the current input transfer
	logic        row_typed = 1'b0;
	gll_item_t   row_exp = '0;

	// predictor copy of the capture state
	logic [7:0]  cap_buf [DEPTH];
	int          cap_wr;
	int          cap_match;
	bit          cap_in_sentence;
	bit          cap_held;

	gll_item_t   sentence_q [$];
	gll_item_t   got_item;
	gll_item_t   want_item;

	int          errors;
	int          n_in;
	int          n_out;
	int          n_sentences;
	int          n_none_held;
	int          n_full_writes;
	int          n_items;
	int          idle_run;
	int          rx_hold;
	bit          steady;

	stim_row_t   dir_rows [DIR_ROWS];

	nmea_gll_sentence_capture_unit #(
		.STORE_DEPTH(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.overrun   (overrun),
		.read_limit(read_limit),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ready_res (ready_res),
		.out_char  (out_char),
		.last      (last)
	);

	always #5 clk = ~clk;

	task automatic report_fault(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("mismatch: %s", msg);
		end
	endtask

	task automatic predict_sentence(input logic k, input logic [7:0] b, input logic ovr,
			input logic [15:0] lim);
		int cap;
		int i;
		if (k == KIND_BYTE) begin
			if (!cap_held) begin
				if (ovr) begin
					cap_wr = 0;
					cap_match = 0;
				end
				cap_buf[cap_wr] = b;
				if (cap_wr < DEPTH - 1) begin
					cap_wr++;
				end else begin
					n_full_writes++;
				end
				if (!cap_in_sentence && b == GLL_PREFIX[cap_match]) begin
					cap_match++;
					if (cap_match == PREFIX_LEN) begin
						cap_match = 0;
						cap_in_sentence = 1'b1;
					end
				end else begin
					// no recheck of this byte as a new '$'
					cap_match = 0;
					if (!cap_in_sentence) begin
						cap_wr = 0;
					end
				end
				if (cap_in_sentence && cap_wr >= 2 && cap_buf[cap_wr - 1] == CH_LF &&
						cap_buf[cap_wr - 2] == CH_CR) begin
					cap_buf[cap_wr - 2] = CH_NUL;
					cap_in_sentence = 1'b0;
					cap_wr = 0;
					cap_match = 0;
					cap_held = 1'b1;
				end
			end
		end else if (!cap_held) begin
			sentence_q.push_back(NONE_HELD);
			n_none_held++;
		end else begin
			cap = (lim == 0) ? 0 : int'(lim) - 1;
			if (cap > DEPTH - 1) begin
				cap = DEPTH - 1;
			end
			for (i = 0; i < cap && cap_buf[i] != CH_NUL; i++) begin
				sentence_q.push_back('{1'b1, cap_buf[i], 1'b0});
			end
			sentence_q.push_back(END_ONLY);
			cap_held = 1'b0;
			n_sentences++;
		end
	endtask

	// input monitor and result check
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				n_in++;
				predict_sentence(kind, rx_byte, overrun, read_limit);
				// the table value stands in for the final item of the run
				if (row_typed && sentence_q.size() != 0) begin
					sentence_q[sentence_q.size() - 1] = row_exp;
				end
			end
			if (out_valid && out_ready) begin
				n_out++;
				got_item = '{ready_res, out_char, last};
				if (sentence_q.size() == 0) begin
					report_fault($sformatf("result rdy=%0d char=%02h last=%0d with nothing expected",
						got_item.rdy, got_item.ch, got_item.lst));
				end else begin
					want_item = sentence_q.pop_front();
					if (got_item.rdy !== want_item.rdy || got_item.ch !== want_item.ch ||
							got_item.lst !== want_item.lst) begin
						report_fault($sformatf(
							"expected rdy=%0d char=%02h last=%0d, got rdy=%0d char=%02h last=%0d",
							want_item.rdy, want_item.ch, want_item.lst,
							got_item.rdy, got_item.ch, got_item.lst));
					end
				end
			end
		end
	end

	// result side may stall after each transfer, never in steady mode
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				rx_hold = steady ? 0 : $urandom_range(0, 7);
				out_ready <= (rx_hold == 0);
			end else if (rx_hold != 0) begin
				rx_hold = rx_hold - 1;
				out_ready <= (rx_hold == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_run <= 0;
			end else begin
				idle_run <= idle_run + 1;
			end
			if (idle_run >= IDLE_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results still due", idle_run,
					sentence_q.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic push_item(input logic k, input logic [7:0] b, input logic ovr,
			input logic [15:0] lim, input logic typed, input gll_item_t res);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		rx_byte    <= b;
		overrun    <= ovr;
		read_limit <= lim;
		row_typed  <= typed;
		row_exp    <= res;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic ovr);
		push_item(KIND_BYTE, b, ovr, 16'($urandom_range(0, 65535)), 1'b0, FROM_PREDICT);
		n_items++;
	endtask

	task automatic send_read(input logic [15:0] lim);
		push_item(KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), lim, 1'b0,
			FROM_PREDICT);
		n_items++;
	endtask

	task automatic wait_drained();
		while (sentence_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] draw_limit();
		case ($urandom_range(0, 7))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3:       return 16'($urandom_range(0, 65535));
			4:       return 16'($urandom_range(60, 66));
			default: return 16'($urandom_range(2, 20));
		endcase
	endfunction

	function automatic logic [7:0] draw_char();
		if ($urandom_range(0, 4) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(32, 126));
	endfunction

	initial begin
		int r;
		int i;
		int j;
		int body_len;
		int ovr_at;
		int next_pause;
		stim_row_t row;

		foreach (cap_buf[i]) begin
			cap_buf[i] = CH_NUL;
		end
		cap_wr = 0;
		cap_match = 0;
		cap_in_sentence = 1'b0;
		cap_held = 1'b0;
		errors = 0;
		n_in = 0;
		n_out = 0;
		n_sentences = 0;
		n_none_held = 0;
		n_full_writes = 0;
		n_items = 0;
		idle_run = 0;
		rx_hold = 0;
		steady = 1'b0;

		dir_rows = '{
			'{KIND_READ, 8'h00, 1'b0, 16'h0000, 1'b1, NONE_HELD},
			'{KIND_BYTE, 8'hFF, 1'b1, 16'hFFFF, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "$",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "G",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			// mismatch in the middle of the prefix
			'{KIND_BYTE, "X",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "$",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "G",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "N",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "G",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "L",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "L",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, ",",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			// overrun after the prefix keeps capturing from entry 0
			'{KIND_BYTE, "A",   1'b1, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, CH_CR, 1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, CH_LF, 1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			// ignored while a sentence is held, overrun included
			'{KIND_BYTE, 8'h00, 1'b1, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_READ, 8'h00, 1'b0, 16'hFFFF, 1'b0, FROM_PREDICT},
			'{KIND_READ, 8'hFF, 1'b1, 16'hFFFF, 1'b1, NONE_HELD},
			'{KIND_BYTE, "$",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "G",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "N",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "G",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "L",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, "L",   1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, CH_CR, 1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_BYTE, CH_LF, 1'b0, 16'h0000, 1'b0, FROM_PREDICT},
			'{KIND_READ, 8'h00, 1'b0, 16'h0001, 1'b1, END_ONLY}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			push_item(row.k, row.b, row.ovr, row.lim, row.typed, row.res);
		end
		in_valid <= 1'b0;
		wait_drained();

		next_pause = 90;
		while (n_items < RAND_ITEMS) begin
			steady = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 9);
			if (r == 0) begin
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)),
					$urandom_range(0, 3) == 0);
			end else if (r == 1) begin
				// prefix cut short: repeated '$', overrun or stray character
				j = $urandom_range(1, 5);
				for (i = 0; i < j; i++) begin
					send_byte(GLL_PREFIX[i], 1'b0);
				end
				case ($urandom_range(0, 2))
					0:       send_byte(GLL_PREFIX[0], 1'b0);
					1:       send_byte(draw_char(), 1'b1);
					default: send_byte(draw_char(), 1'b0);
				endcase
			end else if (r == 2) begin
				send_read(draw_limit());
			end else begin
				for (i = 0; i < PREFIX_LEN; i++) begin
					send_byte(GLL_PREFIX[i], i == 0 && $urandom_range(0, 7) == 0);
				end
				case ($urandom_range(0, 19))
					0, 1, 2: body_len = $urandom_range(50, 58);
					3, 4, 5: body_len = $urandom_range(59, 75);
					default: body_len = $urandom_range(0, 16);
				endcase
				ovr_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, body_len) : -1;
				for (i = 0; i < body_len; i++) begin
					send_byte(draw_char(), i == ovr_at);
				end
				send_byte(CH_CR, 1'b0);
				send_byte(CH_LF, 1'b0);
				// a full store never sees the terminator, restart from entry 0
				if (body_len > 55) begin
					send_byte("x", 1'b1);
					send_byte(CH_CR, 1'b0);
					send_byte(CH_LF, 1'b0);
				end
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 2)) push_item(KIND_BYTE, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), 1'b0, FROM_PREDICT);
				end
				if ($urandom_range(0, 9) != 0) begin
					send_read(draw_limit());
				end
			end
			if (n_items >= next_pause) begin
				in_valid <= 1'b0;
				wait_drained();
				next_pause += 90;
			end
		end
		send_read(draw_limit());
		in_valid <= 1'b0;
		steady = 1'b0;

		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("run covered %0d input transfers and %0d result transfers", n_in, n_out);
		$display("%0d sentences read back, %0d reads with none held, %0d writes to a full store",
			n_sentences, n_none_held, n_full_writes);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/ngll_pkg.sv
hdl/ngll_capture.sv
hdl/nmea_gll_sentence_capture_unit.sv
bench/tb.sv
